@@ src/base64_stream_encoder_macros.svh @@
// Assertion macros shared by the base64 encoder modules.
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define B64E_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64e: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define B64E_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64e: next-cycle check failed");

`endif

@@ src/b64e_pkg.sv @@
// Package with the types, constants and alphabet function of the base64 encoder.
`default_nettype none

package b64e_pkg;

    // Depth of the command queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Position of the next byte within its 3-byte group.
    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_THIRD  = 2'd2
    } grp_pos_t;

    // One classified byte: up to four characters ready for output.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            fin;
    } b64e_cmd_t;

    // Map a sextet to its character in the standard alphabet.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        if (v < 6'd26) begin
            c = w + 8'd65;
        end else if (v < 6'd52) begin
            c = w + 8'd71;
        end else if (v < 6'd62) begin
            c = w - 8'd4;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/b64e_front.sv @@
// Front part: takes raw bytes, tracks the group position and builds character words.
`default_nettype none
`include "base64_stream_encoder_macros.svh"

module b64e_front
    import b64e_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire logic [7:0] data_byte,
    input  wire logic      final_byte,
    input  wire logic      q_full,
    output logic           q_wr,
    output b64e_cmd_t      q_wdata
);

    grp_pos_t   pos_reg, pos_next;
    logic [3:0] carry_reg, carry_next;

    // State register for group position and leftover bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_FIRST;
            carry_reg <= 4'd0;
        end
        else
        begin
            pos_reg   <= pos_next;
            carry_reg <= carry_next;
        end
    end

    // Classify the byte by position and build its characters and next state.
    always_comb
    begin
        q_wr       = push && !q_full;
        q_wdata    = '0;
        pos_next   = pos_reg;
        carry_next = carry_reg;
        case (pos_reg)
            POS_SECOND:
            begin
                q_wdata.chars[0] = b64_char({carry_reg[1:0], data_byte[7:4]});
                if (final_byte)
                begin
                    q_wdata.chars[1] = b64_char({data_byte[3:0], 2'b00});
                    q_wdata.chars[2] = PAD_CHAR;
                    q_wdata.last_idx = 2'd2;
                end
                else
                begin
                    q_wdata.last_idx = 2'd0;
                end
                if (q_wr)
                begin
                    pos_next   = final_byte ? POS_FIRST : POS_THIRD;
                    carry_next = final_byte ? 4'd0 : data_byte[3:0];
                end
            end
            POS_THIRD:
            begin
                q_wdata.chars[0] = b64_char({carry_reg, data_byte[7:6]});
                q_wdata.chars[1] = b64_char(data_byte[5:0]);
                q_wdata.last_idx = 2'd1;
                if (q_wr)
                begin
                    pos_next   = POS_FIRST;
                    carry_next = 4'd0;
                end
            end
            default:
            begin
                q_wdata.chars[0] = b64_char(data_byte[7:2]);
                if (final_byte)
                begin
                    q_wdata.chars[1] = b64_char({data_byte[1:0], 4'b0000});
                    q_wdata.chars[2] = PAD_CHAR;
                    q_wdata.chars[3] = PAD_CHAR;
                    q_wdata.last_idx = 2'd3;
                end
                else
                begin
                    q_wdata.last_idx = 2'd0;
                end
                if (q_wr)
                begin
                    pos_next   = final_byte ? POS_FIRST : POS_SECOND;
                    carry_next = final_byte ? 4'd0 : {2'b00, data_byte[1:0]};
                end
            end
        endcase
        q_wdata.fin = final_byte;
    end

    // Only two carry bits are kept after the first byte of a group.
    `B64E_ASSERT_IMPLY(a_carry_narrow, pos_reg == POS_SECOND, carry_reg[3:2] == 2'b00)
    // A final byte always closes the group.
    `B64E_ASSERT_NEXT(a_final_resets, q_wr && final_byte, pos_reg == POS_FIRST && carry_reg == 4'd0)

endmodule

`default_nettype wire

@@ src/b64e_queue.sv @@
// Short queue of character words between the front and back parts.
`default_nettype none
`include "base64_stream_encoder_macros.svh"

module b64e_queue
    import b64e_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr,
    input  wire b64e_cmd_t  wdata,
    input  wire logic       rd,
    output b64e_cmd_t       rdata,
    output logic            full,
    output logic            q_empty
);

    b64e_cmd_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rdata   = slot_reg[rptr_reg];

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // The queue is never written when full nor read when empty.
    `B64E_ASSERT_IMPLY(a_no_overflow, wr, !full)
    `B64E_ASSERT_IMPLY(a_no_underflow, rd, !q_empty)

endmodule

`default_nettype wire

@@ src/b64e_back.sv @@
// Back part: holds one character word, handing out a character per cycle on pop.
`default_nettype none
`include "base64_stream_encoder_macros.svh"

module b64e_back
    import b64e_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire b64e_cmd_t  q_rdata,
    input  wire logic       q_empty,
    output logic            q_rd,
    input  wire logic       pop,
    output logic            empty,
    output logic [7:0]      out_char,
    output logic            end_of_message
);

    b64e_cmd_t  cur_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       last_char;
    logic       done;

    assign last_char      = (idx_reg == cur_reg.last_idx);
    assign empty          = !valid_reg;
    assign out_char       = cur_reg.chars[idx_reg];
    assign end_of_message = cur_reg.fin && last_char;

    // The word is used up when its last character is taken.
    assign done = !valid_reg || (pop && last_char);
    assign q_rd = done && !q_empty;

    // Control state: valid flag and character index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (done)
        begin
            valid_reg <= !q_empty;
            idx_reg   <= 2'd0;
        end
        else if (pop)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Current word register.
    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            cur_reg <= q_rdata;
        end
    end

    // The index never runs past the last character of the held word.
    `B64E_ASSERT_IMPLY(a_idx_range, valid_reg, idx_reg <= cur_reg.last_idx)

endmodule

`default_nettype wire

@@ src/base64_stream_encoder.sv @@
// Top level of the streaming base64 encoder.
//
//   Channel  Direction  Handshake          Payload
//   input    in         push / full        data_byte[7:0], final_byte
//   result   out        pop / empty        out_char[7:0], end_of_message
//
// A byte goes through the queue and the back part's word register. The back part
// hands out one character per cycle while pop is high, so the sustained rate is set
// by the characters per byte: one or two in steady state, up to four on a final byte.
// A four-word queue lets the front keep taking bytes while the result side stalls.
// Reset is asynchronous and active low; it empties the queue and restarts the group.
`default_nettype none

module base64_stream_encoder
    import b64e_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    input  wire logic       pop,
    output logic            empty,
    output logic [7:0]      out_char,
    output logic            end_of_message
);

    b64e_cmd_t q_wdata;
    b64e_cmd_t q_rdata;
    logic      q_wr;
    logic      q_rd;
    logic      q_full;
    logic      q_empty;

    assign full = q_full;

    // Front part: classification and character building.
    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .q_full     (q_full),
        .q_wr       (q_wr),
        .q_wdata    (q_wdata)
    );

    // Queue between the two parts.
    b64e_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wdata   (q_wdata),
        .rd      (q_rd),
        .rdata   (q_rdata),
        .full    (q_full),
        .q_empty (q_empty)
    );

    // Back part: one character per cycle to the result side while it pops.
    b64e_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_rdata        (q_rdata),
        .q_empty        (q_empty),
        .q_rd           (q_rd),
        .pop            (pop),
        .empty          (empty),
        .out_char       (out_char),
        .end_of_message (end_of_message)
    );

endmodule

`default_nettype wire
